// ===== rtl/spnt_pkg.sv =====
// Package for the strip pedestal and noise tracker: sizes, codes, types.
// No dependencies.
package spnt_pkg;

  localparam int NumBoards      = 2;
  localparam int GroupsPerBoard = 4;
  localparam int LinksPerGroup  = 6;
  localparam int StripsPerLink  = 128;
  localparam int StripsPerGroup = LinksPerGroup * StripsPerLink;
  localparam int NumGroups      = NumBoards * GroupsPerBoard;
  localparam int NumStrips      = NumGroups * StripsPerGroup;
  localparam int GroupW         = $clog2(NumGroups);
  localparam int AddrW          = $clog2(NumStrips);

  localparam int BoardW = 1;
  localparam int GrpW   = 2;
  localparam int StripW = 10;
  localparam int AdcW   = 10;
  localparam int MeanW  = 26;
  localparam int MsqW   = 32;
  localparam int NoiseW = 16;
  localparam int CntW   = 16;

  localparam int InDataW  = 24;  // 23 bits of fields, padded
  localparam int OutDataW = 88;  // 87 bits of fields, padded

  localparam logic [0:0] CfgFollow = 1'b0;
  localparam logic [0:0] CfgReset  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_MUL, ST_DIV, ST_WRITE, ST_SQRT, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic clr_wr;    // write zero at clear address
    logic read;      // issue store read
    logic mul;       // form numerators
    logic div_start;
    logic wr;        // write back results
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic div_done;
    logic sqrt_done;
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/spnt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module spnt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/spnt_ctrl.sv =====
// Controller state machine for the tracker.
// Depends on spnt_pkg.
module spnt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  spnt_pkg::sts_t  sts_i,
  output spnt_pkg::cmd_t  cmd_o
);
  import spnt_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = sts_i.in_range ? ST_MUL : ST_IDLE;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_done) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_SQRT;
      ST_SQRT:  if (sts_i.sqrt_done) state_d = ST_OUT;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ:  cmd_o.read = sts_i.in_range;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        cmd_o.sqrt_start = 1'b1;
      end
      ST_OUT:   cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_div_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q) == ST_DIV) else $error("write skipped divide");
  a_out_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> state_q == ST_OUT) else $error("stray output load");
endmodule

// ===== rtl/spnt_dp.sv =====
// Datapath: stores, counters, three serial dividers and a serial square root.
// Depends on spnt_pkg and spnt_ram.
module spnt_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spnt_pkg::cmd_t                   cmd_i,
  output spnt_pkg::sts_t                   sts_o,
  input  logic [spnt_pkg::InDataW-1:0]     in_data_i,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [spnt_pkg::OutDataW-1:0]    out_data_o
);
  import spnt_pkg::*;

  // configuration
  logic [CntW-1:0] follow_q, rrate_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_q <= '0;
      rrate_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFollow) follow_q <= cfg_data_i;
      if (cfg_idx_i == CfgReset)  rrate_q  <= cfg_data_i;
    end
  end

  // captured beat: board lowest, then group, strip, adc
  logic [BoardW-1:0] board_q;
  logic [GrpW-1:0]   grp_q;
  logic [StripW-1:0] strip_q;
  logic [AdcW-1:0]   adc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      board_q <= in_data_i[BoardW-1:0];
      grp_q   <= in_data_i[BoardW+:GrpW];
      strip_q <= in_data_i[BoardW+GrpW+:StripW];
      adc_q   <= in_data_i[BoardW+GrpW+StripW+:AdcW];
    end
  end

  assign sts_o.in_range = (32'(board_q) < NumBoards) && (32'(grp_q) < GroupsPerBoard)
                        && (32'(strip_q) < StripsPerGroup);

  logic [GroupW-1:0] gidx;
  logic [AddrW-1:0]  addr;
  assign gidx = GroupW'(32'(board_q) * GroupsPerBoard + 32'(grp_q));
  assign addr = AddrW'(32'(gidx) * StripsPerGroup + 32'(strip_q));

  // clearing pass over stores
  logic [AddrW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
  end
  assign sts_o.clr_last = (32'(clr_q) == NumStrips - 1);

  // group counters and divisor
  logic [CntW-1:0] cnt_q [NumGroups];
  logic [CntW-1:0] div_q, cinc, cclamp, nsel;
  assign cinc   = (cnt_q[gidx] != '1) ? cnt_q[gidx] + 1'b1 : cnt_q[gidx];
  assign cclamp = (follow_q != '0 && cinc > follow_q) ? follow_q : cinc;
  assign nsel   = (strip_q == '0) ? cclamp : div_q;

  logic last_strip;
  assign last_strip = (32'(strip_q) == StripsPerGroup - 1);

  // reset-rate check: div_q % rrate_q == 0, done by serial divider below
  logic rr_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= 16'd1;
      for (int i = 0; i < NumGroups; i++) cnt_q[i] <= '0;
    end else begin
      if (cmd_i.read && strip_q == '0) begin
        cnt_q[gidx] <= cinc;
        div_q <= cclamp;
      end
      if (cmd_i.wr && last_strip && rr_hit) cnt_q[gidx] <= '0;
    end
  end

  // stores
  logic [MeanW-1:0] m_rd;
  logic [MsqW-1:0]  s_rd;
  logic [MeanW-1:0] m_new;
  logic [MsqW-1:0]  s_new;
  logic             st_we;
  logic [AddrW-1:0] st_addr;
  assign st_we   = cmd_i.clr_wr | cmd_i.wr;
  assign st_addr = cmd_i.clr_wr ? clr_q : addr;

  spnt_ram #(.Width(MeanW), .Depth(NumStrips)) u_mean (
    .clk_i, .we_i(st_we), .addr_i(st_addr),
    .wdata_i(cmd_i.clr_wr ? '0 : m_new), .rdata_o(m_rd));
  spnt_ram #(.Width(MsqW), .Depth(NumStrips)) u_msq (
    .clk_i, .we_i(st_we), .addr_i(st_addr),
    .wdata_i(cmd_i.clr_wr ? '0 : s_new), .rdata_o(s_rd));

  // divisor and n-1; numerators old*(n-1) + x are formed straight into the dividers
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] nm1;
  assign nm1 = (div_q == '0) ? '0 : div_q - 1'b1;
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) n_q <= (nsel == '0) ? 16'd1 : nsel;
  end

  // restoring dividers, one quotient bit per cycle; third one does the rate check
  logic [5:0]  dcnt_q;
  logic        dbusy_q;
  logic [47:0] mq_q, sq_q;
  logic [16:0] mr_q, sr_q, rr_r_q;
  logic [15:0] rr_q_q;
  logic [4:0]  rcnt;
  logic [16:0] mtr, str, rtr;
  assign mtr = {mr_q[15:0], mq_q[47]};
  assign str = {sr_q[15:0], sq_q[47]};
  assign rtr = {rr_r_q[15:0], rr_q_q[15]};
  assign rcnt = dcnt_q[4:0];
  assign sts_o.div_done = dbusy_q && dcnt_q == 6'd0;
  assign rr_hit = (rrate_q != '0) && (rr_r_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 6'd48;
    end else if (dbusy_q && dcnt_q != 0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end else begin
      dbusy_q <= 1'b0;
    end
  end

  // mul comes with div_start: one 26x16 and one 32x16 product load the dividers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mr_q <= '0; sr_q <= '0; rr_r_q <= '0;
      rr_q_q <= div_q;
      mq_q <= 48'(m_rd) * 48'(nm1) + (48'(adc_q) << 16);
      sq_q <= 48'(s_rd) * 48'(nm1) + (48'(20'(adc_q) * 20'(adc_q)) << 12);
    end else if (dbusy_q && dcnt_q != 0) begin
      if (mtr >= {1'b0, n_q}) begin
        mr_q <= mtr - {1'b0, n_q}; mq_q <= {mq_q[46:0], 1'b1};
      end else begin
        mr_q <= mtr; mq_q <= {mq_q[46:0], 1'b0};
      end
      if (str >= {1'b0, n_q}) begin
        sr_q <= str - {1'b0, n_q}; sq_q <= {sq_q[46:0], 1'b1};
      end else begin
        sr_q <= str; sq_q <= {sq_q[46:0], 1'b0};
      end
      if (dcnt_q <= 6'd16 && rcnt != 0) begin
        rr_q_q <= {rr_q_q[14:0], 1'b0};
        rr_r_q <= (rtr >= {1'b0, rrate_q}) ? rtr - {1'b0, rrate_q} : rtr;
      end
    end
  end
  // quotients fit the field widths, so the low bits are the new means
  assign m_new = mq_q[MeanW-1:0];
  assign s_new = sq_q[MsqW-1:0];

  // variance: product registered first, then subtract
  logic [51:0] msq_q;
  logic [MsqW-1:0] var_v;
  logic [31:0] msqs;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) msq_q <= 52'(m_new) * 52'(m_new);
  end
  assign msqs  = 32'(msq_q >> 20);

  // serial square root, one result bit per cycle
  logic [31:0] sv_q, sres_q, sbit_q;
  logic        sbusy_q, sfirst_q;
  assign var_v = (s_new > msqs) ? s_new - msqs : '0;
  assign sts_o.sqrt_done = sbusy_q && !sfirst_q && sbit_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sfirst_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      sbusy_q <= 1'b1;
      sfirst_q <= 1'b1;
    end else if (sfirst_q) begin
      sfirst_q <= 1'b0;
    end else if (sbusy_q && sbit_q == '0) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sfirst_q) begin
      sv_q <= var_v;
      sres_q <= '0;
      sbit_q <= 32'h4000_0000;
    end else if (sbusy_q && sbit_q != '0) begin
      if (sv_q >= sres_q + sbit_q) begin
        sv_q <= sv_q - (sres_q + sbit_q);
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // output register
  logic ov_q;
  logic [OutDataW-1:0] od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load)
      od_q <= {1'b0, sres_q[NoiseW-1:0], s_new, m_new, strip_q, grp_q, board_q};
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("result moved");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |-> n_q != '0) else $error("zero divisor");
  a_cnt_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    follow_q != '0 && cmd_i.read && strip_q == '0 |=> div_q <= follow_q)
    else $error("divisor above period");
endmodule

// ===== rtl/strip_pedestal_noise_tracker.sv =====
// Top level of the strip pedestal and noise tracker.
// Depends on spnt_pkg, spnt_ctrl, spnt_dp.
//
// channel | direction | content
// s_axis  | in        | tdata: board[0], group[2:1], strip[12:3], adc[22:13]
// m_axis  | out       | tdata: out_board[0], out_group[2:1], out_strip[12:3],
//         |           |        pedestal[38:13], mean_square[70:39], noise[86:71]
// cfg     | in        | 0 following_period, 1 reset_rate
//
// Each sample passes in turn through idle, read, product, the serial
// divider, write, the square root and output before the next is accepted.
// After reset a clearing pass over all 6144 entries zeroes both stores; no
// sample is taken meanwhile. A new sample is taken once the previous result
// sits in the output register; while a result there is stalled, the next
// waits in OUT.
module strip_pedestal_noise_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spnt_pkg::InDataW-1:0]  s_axis_tdata,  // board, group, strip, adc
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spnt_pkg::OutDataW-1:0] m_axis_tdata,  // out_board, out_group,
                                                       // out_strip, pedestal,
                                                       // mean_square, noise
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i
);
  import spnt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spnt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_free_i(!m_axis_tvalid || m_axis_tready),
    .sts_i(sts), .cmd_o(cmd));

  spnt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_data_i(s_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata));
endmodule

// ===== tb/strip_pedestal_noise_tracker_tb.sv =====
// Testbench for strip_pedestal_noise_tracker: streams ADC samples, predicts each
// pedestal, mean-square and noise beat and checks them in a small scoreboard.
// Depends on spnt_pkg and the strip_pedestal_noise_tracker RTL.
module strip_pedestal_noise_tracker_tb;
  import spnt_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned HoldCycles = 2000;

  typedef struct packed {
    logic [BoardW-1:0] board;
    logic [GrpW-1:0]   group;
    logic [StripW-1:0] strip;
    logic [MeanW-1:0]  pedestal;
    logic [MsqW-1:0]   mean_square;
    logic [NoiseW-1:0] noise;
  } strip_result_t;

  // Tracks per-strip means the way the block should, queues expected beats
  class pedestal_scoreboard;
    logic [MeanW-1:0]  ped_mem [NumStrips];
    logic [MsqW-1:0]   msq_mem [NumStrips];
    logic [CntW-1:0]   evt_cnt [NumGroups];
    logic [CntW-1:0]   divisor;
    logic [15:0]       follow_period;
    logic [15:0]       clear_rate;
    strip_result_t     pending[$];
    int unsigned       n_errors;
    int unsigned       n_checked;

    function new();
      for (int i = 0; i < NumStrips; i++) begin
        ped_mem[i] = '0;
        msq_mem[i] = '0;
      end
      for (int i = 0; i < NumGroups; i++) evt_cnt[i] = '0;
      divisor = 16'd1;
      follow_period = '0;
      clear_rate = '0;
      n_errors = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == CfgFollow) follow_period = val;
      else clear_rate = val;
    endfunction

    // bit-pair integer square root
    function logic [31:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res[31:0];
    endfunction

    function void note_sample(logic [BoardW-1:0] b, logic [GrpW-1:0] g,
                              logic [StripW-1:0] s, logic [AdcW-1:0] adc);
      int unsigned gi, idx;
      logic [16:0] c;
      logic [63:0] n, x, xs, m, ms, sq, var_q;
      logic [31:0] root;
      strip_result_t r;
      if (b >= NumBoards || g >= GroupsPerBoard || s >= StripsPerGroup) return;
      gi = b * GroupsPerBoard + g;
      idx = gi * StripsPerGroup + s;
      if (s == 0) begin
        c = 17'(evt_cnt[gi]);
        if (c < 17'hFFFF) c = c + 17'd1;
        evt_cnt[gi] = c[15:0];
        if (follow_period > 0 && c > 17'(follow_period)) c = 17'(follow_period);
        divisor = c[15:0];
      end
      n = 64'(divisor);
      if (n == 0) n = 64'd1;
      x = 64'(adc) << 16;
      xs = (64'(adc) * 64'(adc)) << 12;
      m = (64'(ped_mem[idx]) * (n - 1) + x) / n;
      ms = (64'(msq_mem[idx]) * (n - 1) + xs) / n;
      m = m & 64'h3FFFFFF;
      ms = ms & 64'hFFFFFFFF;
      ped_mem[idx] = m[MeanW-1:0];
      msq_mem[idx] = ms[MsqW-1:0];
      sq = (m * m) >> 20;
      var_q = (ms > sq) ? ms - sq : '0;
      // last strip of a run may clear the group counter
      if (s == StripsPerGroup - 1)
        if (clear_rate > 0 && (divisor % clear_rate) == 0) evt_cnt[gi] = '0;
      root = floor_sqrt(var_q);
      r.board = b;
      r.group = g;
      r.strip = s;
      r.pedestal = m[MeanW-1:0];
      r.mean_square = ms[MsqW-1:0];
      r.noise = root[NoiseW-1:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_beat(logic [OutDataW-1:0] d);
      strip_result_t e;
      logic [BoardW-1:0] b;
      logic [GrpW-1:0] g;
      logic [StripW-1:0] s;
      logic [MeanW-1:0] p;
      logic [MsqW-1:0] ms;
      logic [NoiseW-1:0] nz;
      b = d[0];
      g = d[2:1];
      s = d[12:3];
      p = d[38:13];
      ms = d[70:39];
      nz = d[86:71];
      if (pending.size() == 0) begin
        $error("unexpected result beat: strip %0d", s);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (b !== e.board) begin
        $error("out_board: expected %0d, got %0d", e.board, b); n_errors++;
      end
      if (g !== e.group) begin
        $error("out_group: expected %0d, got %0d", e.group, g); n_errors++;
      end
      if (s !== e.strip) begin
        $error("out_strip: expected %0d, got %0d", e.strip, s); n_errors++;
      end
      if (p !== e.pedestal) begin
        $error("pedestal: expected %0d, got %0d", e.pedestal, p); n_errors++;
      end
      if (ms !== e.mean_square) begin
        $error("mean_square: expected %0d, got %0d", e.mean_square, ms); n_errors++;
      end
      if (nz !== e.noise) begin
        $error("noise: expected %0d, got %0d", e.noise, nz); n_errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;  // board, group, strip, adc
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;  // out_board, out_group, out_strip,
                                      // pedestal, mean_square, noise
  logic                cfg_we_i;
  logic [0:0]          cfg_idx_i;
  logic [15:0]         cfg_data_i;

  pedestal_scoreboard sb;
  bit          calm;       // no idling in the last part
  bit          hold_req;
  int unsigned cycles;
  int unsigned samples_sent;
  int unsigned ignored_sent;

  strip_pedestal_noise_tracker i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned len;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (len - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic [BoardW-1:0] b, logic [GrpW-1:0] g,
                             logic [StripW-1:0] s, logic [AdcW-1:0] adc);
    int unsigned gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, adc, s, g, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(b, g, s, adc);
    if (s < StripsPerGroup) samples_sent++;
    else ignored_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [AdcW-1:0] pick_adc();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return AdcW'($urandom_range(0, 1023));
    endcase
  endfunction

  // one group run: strip 0, a few strips, usually the last strip
  task automatic send_run();
    logic [BoardW-1:0] b;
    logic [GrpW-1:0] g;
    int unsigned k;
    b = BoardW'($urandom_range(0, 1));
    g = GrpW'($urandom_range(0, 3));
    send_sample(b, g, 0, pick_adc());
    k = $urandom_range(0, 5);
    repeat (k) send_sample(b, g, StripW'($urandom_range(1, StripsPerGroup - 2)),
                           pick_adc());
    if ($urandom_range(0, 3) != 0) send_sample(b, g, StripW'(StripsPerGroup - 1), pick_adc());
  endtask

  task automatic send_noise();
    send_sample(BoardW'($urandom_range(0, 1)), GrpW'($urandom_range(0, 3)),
                StripW'($urandom_range(0, 1023)), pick_adc());
  endtask

  initial begin
    logic [15:0] fp_list [7];
    logic [15:0] rr_list [7];
    int unsigned target;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    samples_sent = 0;
    ignored_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgFollow;
    cfg_data_i = '0;
    fp_list = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd5, 16'd0, 16'd2};
    rr_list = '{16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd0, 16'd3, 16'd4};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, out of range strips, jumps out of order
    write_reg(CfgFollow, 16'd0);
    write_reg(CfgReset, 16'd0);
    send_sample(0, 0, 0, 10'd0);
    send_sample(0, 0, StripW'(StripsPerGroup - 1), 10'd1023);
    send_sample(0, 0, StripW'(StripsPerGroup), 10'd5);
    send_sample(1, 3, 10'd1023, 10'd1023);
    send_sample(1, 3, 0, 10'd1023);
    send_sample(1, 3, 0, 10'd0);
    send_sample(1, 3, 0, 10'd1023);
    send_sample(1, 3, 10'd512, 10'd512);
    send_sample(1, 2, 10'd341, 10'd682);
    send_sample(0, 1, 10'd682, 10'd341);
    send_sample(1, 3, StripW'(StripsPerGroup - 1), 10'd0);
    drain();
    write_reg(CfgFollow, 16'd2);
    write_reg(CfgReset, 16'd2);
    repeat (3) begin
      send_sample(0, 2, 0, 10'd1023);
      send_sample(0, 2, 10'd7, 10'd0);
      send_sample(0, 2, StripW'(StripsPerGroup - 1), 10'd1023);
    end
    drain();

    // random phases over several register settings
    target = 0;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CfgFollow, fp_list[ph]);
      write_reg(CfgReset, rr_list[ph]);
      if (ph == 6) calm = 1'b1;
      if (ph == 2) hold_req = 1'b1;
      target += 260;
      while (samples_sent < target) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_run();
      end
      drain();
    end

    $display("Checked %0d result beats from %0d samples (%0d out of range ignored),",
             sb.n_checked, samples_sent, ignored_sent);
    $display("over seven register settings with stalls on both sides and one long hold.");
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spnt_pkg.sv
rtl/spnt_ram.sv
rtl/spnt_ctrl.sv
rtl/spnt_dp.sv
rtl/strip_pedestal_noise_tracker.sv
tb/strip_pedestal_noise_tracker_tb.sv
